[sv/sll_pkg.sv]
// Shared constants for the stereo lookahead limiter.
// Register indexes, gain format and parameter defaults; no dependencies.
package sll_pkg;

  localparam int DEF_DELAY_DEPTH = 512;
  localparam int DEF_SAMPLE_BITS = 16;

  localparam int GAIN_BITS  = 17;
  localparam int COEFF_BITS = 16;
  localparam int LEN_BITS   = 10;
  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = 16;
  localparam int QUOT_BITS  = 16;

  localparam logic [GAIN_BITS-1:0] UNITY_GAIN = 17'h10000;

  localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ATTACK    = 8'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RELEASE   = 8'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LOOKAHEAD = 8'd3;

  localparam logic [15:0] RST_THRESHOLD = 16'd32768;
  localparam logic [15:0] RST_ATTACK    = 16'd0;
  localparam logic [15:0] RST_RELEASE   = 16'd65000;
  localparam logic [9:0]  RST_LOOKAHEAD = 10'd240;

endpackage

[sv/stereo_lookahead_limiter.sv]
// Stereo lookahead peak limiter: ring delay, shift-subtract divider and one
// shared multiplier under a small sequencer. Depends on sll_pkg.
//
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  left_sample, right_sample
// m_axis    out  m_axis_tvalid/m_axis_tready  left_out, right_out, gain_now
// cfg       in   cfg_valid/cfg_ready          cfg_index, cfg_data
//
// A frame whose peak exceeds the threshold runs the 16-step divider for the
// target gain; a frame whose peak is within the threshold skips it.
// Ring contents read as zero until written (fill count), so no clearing pass.
// rst is synchronous; a stalled result sits in the output register while the
// next frame is taken, and the sequencer waits at its last step if it is full.
module stereo_lookahead_limiter #(
  parameter int DELAY_DEPTH = sll_pkg::DEF_DELAY_DEPTH,
  parameter int SAMPLE_BITS = sll_pkg::DEF_SAMPLE_BITS,
  localparam int IN_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((2 * SAMPLE_BITS + sll_pkg::GAIN_BITS + 7) / 8) * 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [IN_W-1:0]                    s_axis_tdata,  // left_sample, right_sample
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [OUT_W-1:0]                   m_axis_tdata,  // left_out, right_out, gain_now
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sll_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [sll_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int SB = SAMPLE_BITS;
  localparam int GB = sll_pkg::GAIN_BITS;
  localparam int AW = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
  localparam int CW = $clog2(DELAY_DEPTH + 1);
  localparam int TW = (SB > 16) ? SB : 16;
  localparam int RW = TW + 1;
  localparam int MA = ((SB > GB) ? SB : GB) + 1;
  localparam int MB = GB + 1;
  localparam int PW = MA + MB;
  localparam int QB = sll_pkg::QUOT_BITS;
  localparam int DCW = $clog2(QB);

  localparam logic signed [PW-1:0] HALF = PW'(32768);
  localparam logic signed [PW-1:0] SMAX = PW'((64'sd1 <<< (SB - 1)) - 64'sd1);
  localparam logic signed [PW-1:0] SMIN = -PW'(64'sd1 <<< (SB - 1));

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_F1, S_F2, S_F3, S_F4, S_F5, S_F6
  } state_t;

  state_t state;

  logic [15:0] threshold_level;
  logic [15:0] attack_coeff;
  logic [15:0] release_coeff;
  logic [9:0]  lookahead_len;

  logic [2*SB-1:0] frame_ring [DELAY_DEPTH];
  logic [2*SB-1:0] ring_q;
  logic            ring_hit;
  logic [AW-1:0]   ring_pointer;
  logic [CW-1:0]   fill;

  logic [SB-1:0]   peak;
  logic [RW-1:0]   rem;
  logic [QB-1:0]   quot;
  logic [DCW-1:0]  div_cnt;
  logic [GB-1:0]   target;
  logic [GB-1:0]   smoothed_gain;
  logic [GB-1:0]   coeff;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] acc;
  logic [SB-1:0]   left_res;

  logic [SB-1:0] out_left;
  logic [SB-1:0] out_right;
  logic [GB-1:0] out_gain;

  // input side
  logic signed [SB-1:0] in_l, in_r;
  logic [SB-1:0] abs_l, abs_r, peak_in;
  logic [CW-1:0] len_eff, ptr_eff, ptr_inc;
  logic in_fire;

  assign in_l    = $signed(s_axis_tdata[SB-1:0]);
  assign in_r    = $signed(s_axis_tdata[2*SB-1:SB]);
  assign abs_l   = in_l[SB-1] ? (~in_l + SB'(1)) : in_l;
  assign abs_r   = in_r[SB-1] ? (~in_r + SB'(1)) : in_r;
  assign peak_in = (abs_l > abs_r) ? abs_l : abs_r;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    if (32'(lookahead_len) > DELAY_DEPTH) begin
      len_eff = CW'(DELAY_DEPTH);
    end else if (lookahead_len == '0) begin
      len_eff = CW'(1);
    end else begin
      len_eff = CW'(lookahead_len);
    end
    ptr_eff = (CW'(ring_pointer) >= len_eff) ? '0 : CW'(ring_pointer);
    ptr_inc = ptr_eff + CW'(1);
  end

  // ring delay: read-before-write on the same slot
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ring_q <= frame_ring[ptr_eff[AW-1:0]];
      frame_ring[ptr_eff[AW-1:0]] <= s_axis_tdata[2*SB-1:0];
    end
  end

  // divider step
  logic [RW-1:0] rem_sh;
  logic          div_ge;
  assign rem_sh = {rem[RW-2:0], 1'b0};
  assign div_ge = rem_sh >= RW'(peak);

  // shared multiplier operands
  logic signed [MA-1:0] mul_a;
  logic signed [MB-1:0] mul_b;
  logic signed [SB-1:0] dl, dr;
  logic                 mul_en;

  assign dl = ring_hit ? $signed(ring_q[SB-1:0])    : '0;
  assign dr = ring_hit ? $signed(ring_q[2*SB-1:SB]) : '0;

  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (state)
      S_F1: begin
        mul_a = $signed(MA'((target < smoothed_gain) ? attack_coeff : release_coeff));
        mul_b = $signed(MB'(smoothed_gain));
      end
      S_F2: begin
        mul_a = $signed(MA'(sll_pkg::UNITY_GAIN - coeff));
        mul_b = $signed(MB'(target));
      end
      S_F4: begin
        mul_a = MA'(dl);
        mul_b = $signed(MB'(smoothed_gain));
      end
      S_F5: begin
        mul_a = MA'(dr);
        mul_b = $signed(MB'(smoothed_gain));
      end
      default: mul_en = 1'b0;
    endcase
  end

  // filter sum, rounding and clamp
  logic [PW:0]    fsum;
  logic [PW-16:0] graw;
  logic [GB-1:0]  gain_next;
  assign fsum = (PW+1)'($unsigned(acc)) + (PW+1)'($unsigned(prod)) + (PW+1)'(32768);
  assign graw = fsum[PW:16];
  assign gain_next = (graw > (PW-15)'(sll_pkg::UNITY_GAIN)) ? sll_pkg::UNITY_GAIN
                                                           : graw[GB-1:0];

  function automatic logic [SB-1:0] sat_round(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] s;
    s = (p + HALF) >>> 16;
    if (s > SMAX) begin
      return SMAX[SB-1:0];
    end else if (s < SMIN) begin
      return SMIN[SB-1:0];
    end
    return s[SB-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= mul_a * mul_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      threshold_level <= sll_pkg::RST_THRESHOLD;
      attack_coeff    <= sll_pkg::RST_ATTACK;
      release_coeff   <= sll_pkg::RST_RELEASE;
      lookahead_len   <= sll_pkg::RST_LOOKAHEAD;
      ring_pointer    <= '0;
      fill            <= '0;
      smoothed_gain   <= sll_pkg::UNITY_GAIN;
      m_axis_tvalid   <= 1'b0;
      div_cnt         <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sll_pkg::REG_THRESHOLD: threshold_level <= cfg_data;
          sll_pkg::REG_ATTACK:    attack_coeff    <= cfg_data;
          sll_pkg::REG_RELEASE:   release_coeff   <= cfg_data;
          sll_pkg::REG_LOOKAHEAD: lookahead_len   <= cfg_data[sll_pkg::LEN_BITS-1:0];
          default: ;
        endcase
      end
      if (state == S_F6 && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            ring_hit     <= ptr_eff < fill;
            ring_pointer <= (ptr_inc >= len_eff) ? '0 : ptr_inc[AW-1:0];
            if (ptr_eff == fill) begin
              fill <= fill + CW'(1);
            end
            peak    <= peak_in;
            rem     <= RW'(threshold_level);
            quot    <= '0;
            div_cnt <= '0;
            target  <= sll_pkg::UNITY_GAIN;
            if (TW'(peak_in) > TW'(threshold_level)) begin
              state <= S_DIV;
            end else begin
              state <= S_F1;
            end
          end
        end
        S_DIV: begin
          rem     <= div_ge ? (rem_sh - RW'(peak)) : rem_sh;
          quot    <= {quot[QB-2:0], div_ge};
          div_cnt <= div_cnt + DCW'(1);
          if (div_cnt == DCW'(QB - 1)) begin
            target <= GB'({quot[QB-2:0], div_ge});
            state  <= S_F1;
          end
        end
        S_F1: begin
          coeff <= GB'((target < smoothed_gain) ? attack_coeff : release_coeff);
          state <= S_F2;
        end
        S_F2: begin
          acc   <= prod;
          state <= S_F3;
        end
        S_F3: begin
          smoothed_gain <= gain_next;
          state         <= S_F4;
        end
        S_F4: begin
          state <= S_F5;
        end
        S_F5: begin
          left_res <= sat_round(prod);
          state    <= S_F6;
        end
        S_F6: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            out_left      <= left_res;
            out_right     <= sat_round(prod);
            out_gain      <= smoothed_gain;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tdata = OUT_W'({out_gain, out_right, out_left});

  a_gain_clamped: assert property (@(posedge clk) disable iff (rst)
    smoothed_gain <= sll_pkg::UNITY_GAIN)
    else $error("smoothed gain above unity");

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    (32'(fill) <= DELAY_DEPTH) && (32'(ring_pointer) < DELAY_DEPTH))
    else $error("ring pointer or fill count out of range");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while a frame is in progress");

  a_div_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && div_cnt == DCW'(QB - 1)) |=> (state == S_F1))
    else $error("divider did not hand over after its last step");

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for stereo_lookahead_limiter: a behavioural model of
// the ring delay, peak gain computer and smoothed gain predicts every frame.
// Depends on sll_pkg and the limiter RTL; directed, stress and random tests.
`timescale 1ns / 1ps

module testbench;

  localparam int IN_W = 32;
  localparam int OUT_W = 56;
  localparam int DEPTH = sll_pkg::DEF_DELAY_DEPTH;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam logic [sll_pkg::CFG_INDEX_BITS-1:0] REG_UNUSED_LOW  = 8'd4;
  localparam logic [sll_pkg::CFG_INDEX_BITS-1:0] REG_UNUSED_HIGH = 8'hFF;

  typedef struct packed {
    logic [16:0]        gain;
    logic signed [15:0] right;
    logic signed [15:0] left;
  } limited_t;

  logic clk = 1'b0;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata;   // left_sample, right_sample
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;  // left_out, right_out, gain_now
  logic cfg_valid;
  logic cfg_ready;
  logic [sll_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [sll_pkg::CFG_DATA_BITS-1:0] cfg_data;

  // model state
  logic [15:0] thr_level;
  logic [15:0] atk_coeff;
  logic [15:0] rel_coeff;
  logic [9:0] la_len;
  logic signed [15:0] ring_l [DEPTH];
  logic signed [15:0] ring_r [DEPTH];
  int unsigned wr_slot;
  longint gain_q;

  limited_t limited_q[$];
  int errors = 0;
  bit tx_open = 0;
  bit cfg_open = 0;
  bit tx_idle_on = 0;
  bit rx_idle_on = 0;
  int rx_hold = 0;
  int wd_idle = 0;

  stereo_lookahead_limiter uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 90) return $urandom_range(1, 3);
    if (k < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [15:0] pick_sample(input int amp);
    int v;
    case ($urandom_range(0, 19))
      0: v = 32767;
      1: v = -32768;
      2: v = 0;
      3, 4: v = $urandom();
      default: v = int'($urandom_range(0, 2 * amp)) - amp;
    endcase
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] scale_sample(input logic signed [15:0] s,
                                                      input longint g);
    longint p;
    p = (longint'(s) * g + 32768) >>> 16;
    if (p > 32767) p = 32767;
    if (p < -32768) p = -32768;
    return p[15:0];
  endfunction

  function automatic limited_t limit_frame(input logic signed [15:0] l,
                                           input logic signed [15:0] r);
    int unsigned span;
    longint al, ar, peak, tgt, coef, acc;
    logic signed [15:0] dl, dr;
    limited_t res;
    span = 32'(la_len);
    if (span == 0) span = 1;
    if (span > DEPTH) span = DEPTH;
    if (wr_slot >= span) wr_slot = 0;
    dl = ring_l[wr_slot];
    dr = ring_r[wr_slot];
    ring_l[wr_slot] = l;
    ring_r[wr_slot] = r;
    wr_slot = (wr_slot + 1 >= span) ? 0 : wr_slot + 1;
    al = longint'(l);
    ar = longint'(r);
    if (al < 0) al = -al;
    if (ar < 0) ar = -ar;
    peak = (al > ar) ? al : ar;
    tgt = longint'(sll_pkg::UNITY_GAIN);
    if (peak > longint'(thr_level)) tgt = (longint'(thr_level) << 16) / peak;
    coef = (tgt < gain_q) ? longint'(atk_coeff) : longint'(rel_coeff);
    acc = (coef * gain_q + (65536 - coef) * tgt + 32768) >> 16;
    if (acc > longint'(sll_pkg::UNITY_GAIN)) acc = longint'(sll_pkg::UNITY_GAIN);
    gain_q = acc;
    res.left = scale_sample(dl, gain_q);
    res.right = scale_sample(dr, gain_q);
    res.gain = gain_q[16:0];
    return res;
  endfunction

  task automatic send_frame(input logic signed [15:0] l, input logic signed [15:0] r);
    int gap;
    if (cfg_open) begin
      cfg_valid <= 1'b0;
      cfg_open = 0;
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {r, l};
    do @(posedge clk); while (!s_axis_tready);
    limited_q.push_back(limit_frame(l, r));
    gap = tx_idle_on ? gap_len() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      tx_open = 0;
      repeat (gap) @(posedge clk);
    end else begin
      tx_open = 1;
    end
  endtask

  task automatic drain_results();
    if (tx_open) begin
      s_axis_tvalid <= 1'b0;
      tx_open = 0;
    end
    while (limited_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [sll_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [sll_pkg::CFG_DATA_BITS-1:0] val);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    cfg_open = 1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      sll_pkg::REG_THRESHOLD: thr_level = val;
      sll_pkg::REG_ATTACK:    atk_coeff = val;
      sll_pkg::REG_RELEASE:   rel_coeff = val;
      sll_pkg::REG_LOOKAHEAD: la_len = val[9:0];
      default: ;
    endcase
  endtask

  task automatic check_frame(input logic [OUT_W-1:0] d);
    limited_t want;
    if (limited_q.size() == 0) begin
      $error("unexpected result: tdata %h", d);
      errors++;
      return;
    end
    want = limited_q.pop_front();
    if (d[15:0] !== want.left) begin
      $error("left_out: expected %0d, got %0d", want.left, $signed(d[15:0]));
      errors++;
    end
    if (d[31:16] !== want.right) begin
      $error("right_out: expected %0d, got %0d", want.right, $signed(d[31:16]));
      errors++;
    end
    if (d[48:32] !== want.gain) begin
      $error("gain_now: expected %0d, got %0d", want.gain, d[48:32]);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) check_frame(m_axis_tdata);
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin : rx_side
    int n;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        n = rx_hold;
        rx_hold = 0;
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (rx_idle_on) begin
        n = gap_len();
        if (n > 0) begin
          m_axis_tready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
      m_axis_tready <= 1'b1;
    end
  end

  // cycles with no transfer on any channel
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      wd_idle <= 0;
    end else begin
      wd_idle <= wd_idle + 1;
    end
    if (wd_idle >= WATCHDOG_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  task automatic test_extremes();
    write_reg(sll_pkg::REG_LOOKAHEAD, 16'd1);
    write_reg(sll_pkg::REG_RELEASE, 16'd0);
    send_frame(16'sh7FFF, 16'sh8000);
    send_frame(16'sh8000, 16'sh7FFF);
    send_frame(16'sh0000, 16'sh0000);
    send_frame(16'shFFFF, 16'sh0001);
    send_frame(16'sh0001, 16'shFFFF);
    // threshold above full scale
    write_reg(sll_pkg::REG_THRESHOLD, 16'hFFFF);
    send_frame(16'sh8000, 16'sh8000);
    send_frame(16'sh5555, 16'shAAAA);
    // threshold zero
    write_reg(sll_pkg::REG_THRESHOLD, 16'd0);
    send_frame(16'sh0000, 16'sh0000);
    send_frame(16'sh0001, 16'sh0000);
    send_frame(16'sh7FFF, 16'sh8000);
    write_reg(sll_pkg::REG_THRESHOLD, 16'd16384);
    write_reg(sll_pkg::REG_ATTACK, 16'hFFFF);
    write_reg(sll_pkg::REG_RELEASE, 16'd32768);
    send_frame(16'sh8000, 16'sh0000);
    send_frame(16'sh4000, 16'sh4001);
    send_frame(16'sh0000, 16'sh0000);
  endtask

  task automatic test_special_cases();
    write_reg(sll_pkg::REG_THRESHOLD, 16'h8000);
    write_reg(sll_pkg::REG_ATTACK, 16'd0);
    // length field of zero, upper data bits ignored
    write_reg(sll_pkg::REG_LOOKAHEAD, 16'h0400);
    repeat (2) send_frame(16'($urandom()), 16'($urandom()));
    // 1023 clips to the ring depth
    write_reg(sll_pkg::REG_LOOKAHEAD, 16'hFFFF);
    repeat (3) send_frame(16'($urandom()), 16'($urandom()));
    // length lowered below the write pointer
    write_reg(sll_pkg::REG_LOOKAHEAD, 16'd2);
    repeat (3) send_frame(16'($urandom()), 16'($urandom()));
    write_reg(REG_UNUSED_LOW, 16'hFFFF);
    write_reg(REG_UNUSED_HIGH, 16'h0000);
    repeat (2) send_frame(16'($urandom()), 16'($urandom()));
  endtask

  task automatic test_full_backpressure();
    write_reg(sll_pkg::REG_THRESHOLD, 16'd8000);
    write_reg(sll_pkg::REG_LOOKAHEAD, 16'd3);
    tx_idle_on = 0;
    rx_idle_on = 0;
    rx_hold = 400;
    repeat (40) send_frame(pick_sample(20000), pick_sample(20000));
    drain_results();
  endtask

  task automatic test_drain_pause();
    tx_idle_on = 1;
    rx_idle_on = 1;
    repeat (20) send_frame(pick_sample(30000), pick_sample(30000));
    drain_results();
    repeat (20) send_frame(pick_sample(30000), pick_sample(30000));
  endtask

  task automatic test_random_settings();
    int amp;
    logic [15:0] v;
    for (int ph = 0; ph < 10; ph++) begin
      case ($urandom_range(0, 5))
        0: v = 16'd0;
        1: v = 16'h8000;
        2: v = 16'hFFFF;
        default: v = 16'($urandom_range(1, 32767));
      endcase
      write_reg(sll_pkg::REG_THRESHOLD, v);
      case ($urandom_range(0, 4))
        0: v = 16'd0;
        1: v = 16'hFFFF;
        default: v = 16'($urandom_range(30000, 65535));
      endcase
      write_reg(sll_pkg::REG_ATTACK, v);
      case ($urandom_range(0, 4))
        0: v = 16'd0;
        1: v = 16'hFFFF;
        default: v = 16'($urandom_range(40000, 65535));
      endcase
      write_reg(sll_pkg::REG_RELEASE, v);
      case ($urandom_range(0, 7))
        0: v = 16'd0;
        1: v = 16'd512;
        2: v = 16'($urandom());
        3: v = 16'($urandom_range(1, 512));
        default: v = 16'($urandom_range(1, 16));
      endcase
      write_reg(sll_pkg::REG_LOOKAHEAD, v);
      tx_idle_on = (ph % 3 != 0);
      rx_idle_on = (ph % 3 != 0);
      amp = $urandom_range(1, 32767);
      repeat (100) send_frame(pick_sample(amp), pick_sample(amp));
    end
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    thr_level = sll_pkg::RST_THRESHOLD;
    atk_coeff = sll_pkg::RST_ATTACK;
    rel_coeff = sll_pkg::RST_RELEASE;
    la_len = sll_pkg::RST_LOOKAHEAD;
    foreach (ring_l[i]) begin
      ring_l[i] = '0;
      ring_r[i] = '0;
    end
    wr_slot = 0;
    gain_q = longint'(sll_pkg::UNITY_GAIN);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    tx_idle_on = 1;
    rx_idle_on = 1;
    test_extremes();
    test_special_cases();
    test_full_backpressure();
    test_drain_pause();
    test_random_settings();
    drain_results();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
